>>> design/nna_pkg.sv
// ----------------------------------------------------------------------------
// nna_pkg
// Shared types and constants for the nearest neighbor association core.
// ----------------------------------------------------------------------------
package nna_pkg;

    // Field widths of a transaction.
    localparam int MODE_BITS  = 2;
    localparam int ID_BITS    = 16;
    localparam int COORD_BITS = 24;

    // Default table depth.
    localparam int MAX_ENTRIES_DEF = 64;

    // Distance arithmetic widths: a coordinate difference needs one more bit,
    // its square at most 2*COORD_BITS+1 bits, and the sum of two squares one more.
    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int SQ_BITS   = 2 * COORD_BITS + 1;
    localparam int SUM_BITS  = SQ_BITS + 1;

    // Command codes carried in the mode field.
    localparam logic [MODE_BITS-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_LOAD  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_QUERY = 2'd2;

    // Request transaction.
    typedef struct packed {
        logic        [MODE_BITS-1:0]  mode;
        logic        [ID_BITS-1:0]    entry_id;
        logic signed [COORD_BITS-1:0] x_coord;
        logic signed [COORD_BITS-1:0] y_coord;
    } in_t;

    // Result transaction.
    typedef struct packed {
        logic [ID_BITS-1:0] matched_id;
        logic               found;
    } out_t;

    // One stored landmark.
    typedef struct packed {
        logic        [ID_BITS-1:0]    id;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } entry_t;

    // Control tag that travels with each table read through the pipeline.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } tag_t;

endpackage

>>> design/nna_table.sv
// ----------------------------------------------------------------------------
// nna_table
// Landmark table: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module nna_table #(
    parameter int DEPTH = nna_pkg::MAX_ENTRIES_DEF,
    parameter int IDX_W = 6
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [IDX_W-1:0]     waddr,
    input  nna_pkg::entry_t      wdata,
    input  logic                 re,
    input  logic [IDX_W-1:0]     raddr,
    output nna_pkg::entry_t      rdata
);

    nna_pkg::entry_t mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, with registered read data.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/nna_dist.sv
// ----------------------------------------------------------------------------
// nna_dist
// Two-stage squared Euclidean distance pipeline: difference, then square.
// ----------------------------------------------------------------------------
module nna_dist (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic signed [nna_pkg::COORD_BITS-1:0]  obs_x,
    input  logic signed [nna_pkg::COORD_BITS-1:0]  obs_y,
    input  nna_pkg::entry_t                        ent,
    input  nna_pkg::tag_t                          tag_in,
    output logic        [nna_pkg::SUM_BITS-1:0]    sum,
    output logic        [nna_pkg::ID_BITS-1:0]     id,
    output nna_pkg::tag_t                          tag_out
);

    logic signed [nna_pkg::DIFF_BITS-1:0] dx_reg;
    logic signed [nna_pkg::DIFF_BITS-1:0] dy_reg;
    logic        [nna_pkg::ID_BITS-1:0]   id1_reg;
    nna_pkg::tag_t                        tag1_reg;
    logic        [nna_pkg::SQ_BITS-1:0]   sqx_reg;
    logic        [nna_pkg::SQ_BITS-1:0]   sqy_reg;
    logic        [nna_pkg::ID_BITS-1:0]   id2_reg;
    nna_pkg::tag_t                        tag2_reg;
    logic signed [2*nna_pkg::DIFF_BITS-1:0] prod_x;
    logic signed [2*nna_pkg::DIFF_BITS-1:0] prod_y;

    // Tags carry the control flow and are cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
        end
    end

    // Stage one: exact coordinate differences.
    always_ff @(posedge clk)
    begin
        dx_reg  <= nna_pkg::DIFF_BITS'(obs_x) - nna_pkg::DIFF_BITS'(ent.x);
        dy_reg  <= nna_pkg::DIFF_BITS'(obs_y) - nna_pkg::DIFF_BITS'(ent.y);
        id1_reg <= ent.id;
    end

    // Stage two: squares, which are never negative and fit in SQ_BITS.
    assign prod_x = dx_reg * dx_reg;
    assign prod_y = dy_reg * dy_reg;

    always_ff @(posedge clk)
    begin
        sqx_reg <= prod_x[nna_pkg::SQ_BITS-1:0];
        sqy_reg <= prod_y[nna_pkg::SQ_BITS-1:0];
        id2_reg <= id1_reg;
    end

    // Sum of squares, consumed by the compare stage.
    assign sum     = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign id      = id2_reg;
    assign tag_out = tag2_reg;

endmodule

>>> design/nearest_neighbour_association_core.sv
// ----------------------------------------------------------------------------
// nearest_neighbour_association_core
// Nearest neighbor search over a table of landmarks by squared distance.
// ----------------------------------------------------------------------------
// A request transaction is taken at a clock edge where start is high and busy
// is low. Its mode selects the command. A clear empties the table and a load
// appends one entry; both finish at the accepting edge, give no result and
// leave busy low. A load into a full table is dropped.
// A query raises busy and walks the stored entries through the single read
// port of the table, one entry per cycle, then through a difference stage,
// a square stage and a compare stage. A query holds busy until its last entry
// has passed the compare stage; busy falls in the same cycle that done rises
// with its result, and no new request is taken while busy is high. A query
// on an empty table answers in the next cycle with found low and matched_id
// zero. Each result is driven on result for exactly one cycle with done high.
// The receiver cannot stall, so results are never held back.
// Reset empties the table and returns the control to idle. Table contents are
// not cleared; entries beyond the fill count are never read.
// ----------------------------------------------------------------------------
module nearest_neighbour_association_core #(
    parameter int MAX_ENTRIES = nna_pkg::MAX_ENTRIES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  nna_pkg::in_t  request,
    output logic          done,
    output nna_pkg::out_t result
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;

    logic [1:0]                               state_reg, state_next;
    logic [CNT_W-1:0]                         count_reg, count_next;
    logic [IDX_W-1:0]                         idx_reg, idx_next;
    logic signed [nna_pkg::COORD_BITS-1:0]    obs_x_reg, obs_x_next;
    logic signed [nna_pkg::COORD_BITS-1:0]    obs_y_reg, obs_y_next;
    nna_pkg::tag_t                            rd_tag_reg, rd_tag_next;
    logic [nna_pkg::SUM_BITS-1:0]             best_sum_reg, best_sum_next;
    logic [nna_pkg::ID_BITS-1:0]              best_id_reg, best_id_next;
    logic                                     done_reg, done_next;
    nna_pkg::out_t                            result_reg, result_next;

    logic                                     accept;
    logic                                     table_full;
    logic                                     mem_we;
    logic                                     mem_re;
    logic                                     issue_last;
    nna_pkg::entry_t                          wr_entry;
    nna_pkg::entry_t                          rd_entry;
    logic [nna_pkg::SUM_BITS-1:0]             cmp_sum;
    logic [nna_pkg::ID_BITS-1:0]              cmp_id;
    nna_pkg::tag_t                            cmp_tag;
    logic                                     take;

    assign accept     = start && !busy;
    assign table_full = (count_reg == CNT_W'(MAX_ENTRIES));
    assign mem_we     = accept && (request.mode == nna_pkg::MODE_LOAD) && !table_full;
    assign mem_re     = (state_reg == ST_ISSUE);
    assign issue_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    assign wr_entry.id = request.entry_id;
    assign wr_entry.x  = request.x_coord;
    assign wr_entry.y  = request.y_coord;

    // Landmark storage.
    nna_table #(
        .DEPTH (MAX_ENTRIES),
        .IDX_W (IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (wr_entry),
        .re    (mem_re),
        .raddr (idx_reg),
        .rdata (rd_entry)
    );

    // Distance pipeline fed by the table read data.
    nna_dist u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .obs_x   (obs_x_reg),
        .obs_y   (obs_y_reg),
        .ent     (rd_entry),
        .tag_in  (rd_tag_reg),
        .sum     (cmp_sum),
        .id      (cmp_id),
        .tag_out (cmp_tag)
    );

    // A strictly smaller distance replaces the best; ties keep the earlier entry.
    assign take = cmp_tag.valid && (cmp_tag.first || (cmp_sum < best_sum_reg));

    // Command decode, scan control and compare stage.
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        obs_x_next    = obs_x_reg;
        obs_y_next    = obs_y_reg;
        best_sum_next = best_sum_reg;
        best_id_next  = best_id_reg;
        done_next     = 1'b0;
        result_next   = result_reg;

        rd_tag_next.valid = mem_re;
        rd_tag_next.first = (idx_reg == '0);
        rd_tag_next.last  = issue_last;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (request.mode == nna_pkg::MODE_CLEAR)
                    begin
                        count_next = '0;
                    end
                    else if (request.mode == nna_pkg::MODE_LOAD)
                    begin
                        if (!table_full)
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (request.mode == nna_pkg::MODE_QUERY)
                    begin
                        if (count_reg == '0)
                        begin
                            done_next              = 1'b1;
                            result_next.matched_id = '0;
                            result_next.found      = 1'b0;
                        end
                        else
                        begin
                            obs_x_next = request.x_coord;
                            obs_y_next = request.y_coord;
                            idx_next   = '0;
                            state_next = ST_ISSUE;
                        end
                    end
                    else
                    begin
                        // Unused mode: nothing happens.
                        count_next = count_reg;
                    end
                end
            end
            ST_ISSUE:
            begin
                if (issue_last)
                begin
                    state_next = ST_WAIT;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_WAIT:
            begin
                if (cmp_tag.valid && cmp_tag.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Compare stage: fold the entry into the running best.
        if (take)
        begin
            best_sum_next = cmp_sum;
            best_id_next  = cmp_id;
        end
        if (cmp_tag.valid && cmp_tag.last)
        begin
            done_next              = 1'b1;
            result_next.found      = 1'b1;
            result_next.matched_id = take ? cmp_id : best_id_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            rd_tag_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            rd_tag_reg <= rd_tag_next;
            done_reg   <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        obs_x_reg    <= obs_x_next;
        obs_y_reg    <= obs_y_next;
        best_sum_reg <= best_sum_next;
        best_id_reg  <= best_id_next;
        result_reg   <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef NO_ASSERTIONS
    // A result only follows the end of a scan or a query on an empty table.
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == ST_WAIT) ||
                 ($past(accept) && ($past(request.mode) == nna_pkg::MODE_QUERY)))
        else $error("result without a query");

    // An empty result carries a zero id.
    a_empty_id: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.found) |-> (result.matched_id == '0))
        else $error("empty result with nonzero id");

    // The fill count never passes the table depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("fill count beyond table depth");

    // The table is never written while a scan reads it.
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !mem_we)
        else $error("table write during scan");
`endif

endmodule

>>> dv/tb_nearest_neighbour_association_core.sv
// ----------------------------------------------------------------------------
// tb_nearest_neighbour_association_core
// Self-checking testbench for the nearest neighbor association core.
// ----------------------------------------------------------------------------
// A directed sequence covers the coordinate extremes, every command, ties,
// empty-table queries and the unused mode. A long random sequence follows,
// built from episodes that clear the table, load a set of landmarks and
// query points near, on or away from them; some episodes overfill the table.
// A scoreboard keeps its own copy of the landmark table, predicts the nearest
// landmark for every accepted query and compares each result field by field.
// ----------------------------------------------------------------------------
module tb_nearest_neighbour_association_core;

    localparam int TABLE_DEPTH  = nna_pkg::MAX_ENTRIES_DEF;
    localparam int ITEM_TARGET  = 1250;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 80;
    localparam int REPORT_MAX   = 10;

    // The fourth mode code has no command behind it.
    localparam logic [nna_pkg::MODE_BITS-1:0] MODE_UNUSED = 2'd3;

    localparam logic signed [nna_pkg::COORD_BITS-1:0] COORD_MIN =
        {1'b1, {(nna_pkg::COORD_BITS-1){1'b0}}};
    localparam logic signed [nna_pkg::COORD_BITS-1:0] COORD_MAX =
        {1'b0, {(nna_pkg::COORD_BITS-1){1'b1}}};

    // ------------------------------------------------------------------------
    // Scoreboard: landmark table copy, nearest-match prediction and checking.
    // ------------------------------------------------------------------------
    class association_checker;
        logic signed [nna_pkg::COORD_BITS-1:0] land_x [TABLE_DEPTH];
        logic signed [nna_pkg::COORD_BITS-1:0] land_y [TABLE_DEPTH];
        logic        [nna_pkg::ID_BITS-1:0]    land_id[TABLE_DEPTH];
        int                                    land_count;
        nna_pkg::out_t                         pending_matches[$];
        int                                    mismatches;

        function new();
            land_count = 0;
            mismatches = 0;
        endfunction

        // Nearest stored landmark to a point by exact squared distance.
        function nna_pkg::out_t nearest_match(logic signed [nna_pkg::COORD_BITS-1:0] px,
                                              logic signed [nna_pkg::COORD_BITS-1:0] py);
            nna_pkg::out_t match;
            longint        dx;
            longint        dy;
            longint        sq_dist;
            longint        best_dist;
            match      = '0;
            best_dist  = 0;
            for (int i = 0; i < land_count; i++)
            begin
                dx      = longint'(px) - longint'(land_x[i]);
                dy      = longint'(py) - longint'(land_y[i]);
                sq_dist = dx * dx + dy * dy;
                // Strictly less keeps the earliest landmark on a tie.
                if (!match.found || sq_dist < best_dist)
                begin
                    match.found      = 1'b1;
                    match.matched_id = land_id[i];
                    best_dist        = sq_dist;
                end
            end
            return match;
        endfunction

        // Update the table copy for an accepted request transaction.
        function void note_request(nna_pkg::in_t req);
            logic signed [nna_pkg::COORD_BITS-1:0] px;
            logic signed [nna_pkg::COORD_BITS-1:0] py;
            px = req.x_coord;
            py = req.y_coord;
            case (req.mode)
                nna_pkg::MODE_CLEAR: land_count = 0;
                nna_pkg::MODE_LOAD:
                begin
                    if (land_count < TABLE_DEPTH)
                    begin
                        land_x[land_count]  = px;
                        land_y[land_count]  = py;
                        land_id[land_count] = req.entry_id;
                        land_count++;
                    end
                end
                nna_pkg::MODE_QUERY:
                    pending_matches = {pending_matches, nearest_match(px, py)};
                default: ;
            endcase
        endfunction

        // Compare a result transaction with the oldest prediction.
        function void check_result(nna_pkg::out_t res);
            nna_pkg::out_t want;
            if (pending_matches.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("ERROR: result with none expected: id %h found %b",
                             res.matched_id, res.found);
                return;
            end
            want = pending_matches.pop_front();
            if (res.matched_id !== want.matched_id || res.found !== want.found)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("ERROR: expected id %h found %b, got id %h found %b",
                             want.matched_id, want.found, res.matched_id, res.found);
            end
        endfunction

        function int pending();
            return pending_matches.size();
        endfunction
    endclass

    logic           clk = 1'b0;
    logic           rst_n;
    logic           start;
    logic           busy;
    nna_pkg::in_t   request;
    logic           done;
    nna_pkg::out_t  result;

    association_checker sb = new();
    int                 idle_cycles = 0;
    int                 items_sent  = 0;
    bit                 no_idle     = 1'b0;
    nna_pkg::entry_t    loaded_points[$];

    nearest_neighbour_association_core #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .request(request),
        .done   (done),
        .result (result)
    );

    always #5 clk = ~clk;

    // Monitor: note accepted requests, check results, track progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(result);
            if (start && !busy)
                sb.note_request(request);
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog: stop the run when nothing moves for too long.
    initial
    begin
        do @(posedge clk); while (idle_cycles < IDLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // Gap after a transaction: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        else if (r < 87)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Random landmark id at the field width.
    function automatic logic [nna_pkg::ID_BITS-1:0] rand_id();
        logic [31:0] raw;
        raw = $urandom();
        return raw[nna_pkg::ID_BITS-1:0];
    endfunction

    // Coordinate of a given flavor: full range, clustered near zero, or edges.
    function automatic logic signed [nna_pkg::COORD_BITS-1:0] pick_coord(int flavor);
        int      v;
        logic [31:0] raw;
        raw = $urandom();
        case (flavor)
            1:
            begin
                v = int'($urandom_range(0, 32)) - 16;
                return v[nna_pkg::COORD_BITS-1:0];
            end
            2:
            begin
                case ($urandom_range(0, 4))
                    0: return COORD_MIN;
                    1: return COORD_MAX;
                    2: return '0;
                    3: return '1;
                    default: return raw[nna_pkg::COORD_BITS-1:0];
                endcase
            end
            default: return raw[nna_pkg::COORD_BITS-1:0];
        endcase
    endfunction

    // Coordinate a few steps away from a base value, wrapping at the width.
    function automatic logic signed [nna_pkg::COORD_BITS-1:0] nudge(
        logic signed [nna_pkg::COORD_BITS-1:0] base, int spread);
        int s;
        s = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
        return s[nna_pkg::COORD_BITS-1:0];
    endfunction

    // Drive one request transaction and hold it until accepted.
    task automatic issue(logic [nna_pkg::MODE_BITS-1:0] mode,
                         logic [nna_pkg::ID_BITS-1:0] id,
                         logic signed [nna_pkg::COORD_BITS-1:0] x,
                         logic signed [nna_pkg::COORD_BITS-1:0] y);
        nna_pkg::in_t    item;
        nna_pkg::entry_t pt;
        int              gap;
        item.mode     = mode;
        item.entry_id = id;
        item.x_coord  = x;
        item.y_coord  = y;
        // Keep the stimulus view of the table in step with the block.
        case (mode)
            nna_pkg::MODE_CLEAR:
            begin
                loaded_points.delete();
                items_sent++;
            end
            nna_pkg::MODE_LOAD:
            begin
                if (loaded_points.size() < TABLE_DEPTH)
                begin
                    pt.id = id;
                    pt.x  = x;
                    pt.y  = y;
                    loaded_points = {loaded_points, pt};
                    items_sent++;
                end
            end
            nna_pkg::MODE_QUERY: items_sent++;
            default: ;
        endcase
        gap = pick_gap();
        request <= item;
        start   <= 1'b1;
        do @(posedge clk); while (busy);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Query point: on, near or away from a stored landmark.
    task automatic random_query();
        nna_pkg::entry_t pt;
        int              r;
        r = $urandom_range(0, 9);
        if (loaded_points.size() > 0 && r < 6)
        begin
            pt = loaded_points[$urandom_range(0, loaded_points.size() - 1)];
            if (r < 2)
                issue(nna_pkg::MODE_QUERY, rand_id(), pt.x, pt.y);
            else
                issue(nna_pkg::MODE_QUERY, rand_id(), nudge(pt.x, 8), nudge(pt.y, 8));
        end
        else
            issue(nna_pkg::MODE_QUERY, rand_id(), pick_coord(r % 3), pick_coord(r % 3));
    endtask

    // One episode: optional clear, a set of loads, then queries and noise.
    task automatic random_episode();
        int              r;
        int              loads;
        int              queries;
        int              flavor;
        nna_pkg::entry_t pt;
        no_idle = ($urandom_range(0, 4) == 0);
        flavor  = $urandom_range(0, 2);
        if ($urandom_range(0, 9) != 0)
            issue(nna_pkg::MODE_CLEAR, rand_id(), pick_coord(0), pick_coord(0));
        r = $urandom_range(0, 9);
        if (r < 7)
            loads = $urandom_range(0, 8);
        else if (r < 9)
            loads = $urandom_range(9, 40);
        else
            loads = $urandom_range(60, 70);
        for (int i = 0; i < loads; i++)
        begin
            // Reuse a stored position now and then so that ties arise.
            if (loaded_points.size() > 0 && $urandom_range(0, 7) == 0)
            begin
                pt = loaded_points[$urandom_range(0, loaded_points.size() - 1)];
                issue(nna_pkg::MODE_LOAD, rand_id(), pt.x, pt.y);
            end
            else
                issue(nna_pkg::MODE_LOAD, rand_id(), pick_coord(flavor),
                      pick_coord(flavor));
        end
        if ($urandom_range(0, 9) == 0)
            issue(MODE_UNUSED, rand_id(), pick_coord(0), pick_coord(0));
        queries = $urandom_range(1, 6);
        for (int i = 0; i < queries; i++)
        begin
            random_query();
            // Interleave a late load with the queries at times.
            if ($urandom_range(0, 11) == 0)
                issue(nna_pkg::MODE_LOAD, rand_id(), pick_coord(flavor),
                      pick_coord(flavor));
        end
    endtask

    // Main sequence: reset, directed cases, random episodes, drain, verdict.
    initial
    begin
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases on corners, ties, duplicates and the empty table.
        issue(nna_pkg::MODE_QUERY, 16'h0000, '0, '0);
        issue(MODE_UNUSED, 16'hFFFF, '1, '1);
        issue(nna_pkg::MODE_LOAD, 16'h0000, COORD_MIN, COORD_MIN);
        issue(nna_pkg::MODE_LOAD, 16'hFFFF, COORD_MAX, COORD_MAX);
        issue(nna_pkg::MODE_QUERY, 16'hFFFF, COORD_MIN, COORD_MAX);
        issue(nna_pkg::MODE_QUERY, 16'h0000, COORD_MAX, COORD_MAX);
        issue(nna_pkg::MODE_QUERY, 16'h0000, COORD_MIN, COORD_MIN);
        issue(nna_pkg::MODE_LOAD, 16'h1234, '0, '0);
        issue(nna_pkg::MODE_LOAD, 16'hABCD, '0, '0);
        issue(nna_pkg::MODE_QUERY, 16'h5555, 24'sd1, -24'sd1);
        issue(nna_pkg::MODE_QUERY, 16'hAAAA, COORD_MAX, COORD_MIN);
        issue(nna_pkg::MODE_CLEAR, 16'hFFFF, COORD_MAX, COORD_MIN);
        issue(nna_pkg::MODE_QUERY, 16'h0000, '0, '0);
        issue(nna_pkg::MODE_LOAD, 16'h5A5A, '1, '1);
        issue(nna_pkg::MODE_QUERY, 16'h0000, COORD_MAX, COORD_MAX);
        issue(nna_pkg::MODE_CLEAR, 16'h0000, '0, '0);

        // Random episodes until the item count is reached.
        while (items_sent < ITEM_TARGET)
            random_episode();
        start <= 1'b0;

        // Drain outstanding results, then allow the pipeline to settle.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
